FILE: hw/rtl/rlcm_pkg.sv
// shared types and constants of the relative low-contrast mask unit
// no dependencies
package rlcm_pkg;

  // histogram geometry
  localparam int unsigned BIN_W   = 8;
  localparam int unsigned NUM_BIN = 256;

  // shared divider: sum of top values / count, or pixel budget / block size
  localparam int unsigned DIV_N_W   = 24;
  localparam int unsigned DIV_D_W   = 17;
  localparam int unsigned DIV_CNT_W = 5;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration register widths and indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned SS_W       = 22;
  localparam int unsigned PPB_W      = 17;
  localparam int unsigned FRAC_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIX_PER_BLK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FRAC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_LIMIT    = 2'd3;

  localparam logic [SS_W-1:0]   SAMPLE_SIZE_RST = 22'd168568;
  localparam logic [PPB_W-1:0]  PIX_PER_BLK_RST = 17'd256;
  localparam logic [FRAC_W-1:0] SAMPLE_FRAC_RST = 16'd32113;
  localparam logic [FRAC_W-1:0] REL_LIMIT_RST   = 16'd22282;

  // input selector and output kind codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;
  localparam logic KIND_LIMIT  = 1'b0;
  localparam logic KIND_CLASS  = 1'b1;

  // histogram memory access request
  typedef struct packed {
    logic             rd_en;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    logic             clr;
  } hist_req_t;

endpackage

FILE: hw/rtl/rlcm_hist.sv
// 256-bin histogram memory with per-bin valid bits, cleared all at once through those bits
// depends on rlcm_pkg
module rlcm_hist import rlcm_pkg::*; #(
  parameter int unsigned DATA_W = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hist_req_t         req_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0]  mem [NUM_BIN];
  logic [DATA_W-1:0]  rd_data_q;
  logic [NUM_BIN-1:0] vld_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // bins never written since the last clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

FILE: hw/rtl/rlcm_div.sv
// restoring divider, one quotient bit per cycle
// depends on rlcm_pkg
module rlcm_div import rlcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_D_W:0]     rem_q, rem_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;
  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W:0]     dvs_ext;

  assign rem_sh  = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
  assign dvs_ext = {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_N_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= dvs_ext) begin
        rem_d = rem_sh - dvs_ext;
        quo_d = {quo_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DIV_N_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: hw/rtl/rlcm_mul.sv
// shared 17 x 16 multiplier with registered product
// depends on rlcm_pkg
module rlcm_mul import rlcm_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/relative_low_contrast_mask_unit.sv
// top level of the relative low-contrast mask unit
// depends on rlcm_pkg, rlcm_hist, rlcm_div and rlcm_mul

// Load transfers (tuser 0) count one block contrast byte each into a
// 256-bin histogram; a load reads and writes back the histogram memory,
// and loads beyond MAX_BLOCKS are not counted. The load marked by tlast
// then triggers the limit computation: the pixel budget is divided by the
// block size, the smaller of that and the loaded count is scaled by the
// sample fraction to give K (at least 1), the histogram is walked from bin
// 255 downward until K values are summed or bin 0 is reached, the sum is
// divided by K and scaled by the relative limit. One multiplier and one
// divider serve all steps. The result transfer carries kind 0 and the new
// limit; the histogram and the count are then empty again at once through
// per-bin valid bits, so no clearing pass follows. Classify transfers
// (tuser 1) return kind 1, the low-contrast flag (contrast below limit)
// and the limit. The result register lets the next transfer in as the
// current one leaves; configuration writes belong in idle stretches with
// nothing in flight, as a computation reads the registers while it runs.
module relative_low_contrast_mask_unit import rlcm_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // contrast
  input  logic                  s_axis_tuser,   // op
  input  logic                  s_axis_tlast,   // last
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // low_contrast, limit, zero fill
  output logic                  m_axis_tuser    // kind
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_LOAD  = 9'b0_0000_0010,
    ST_SDIV  = 9'b0_0000_0100,
    ST_KMUL  = 9'b0_0000_1000,
    ST_WTAKE = 9'b0_0001_0000,
    ST_WACC  = 9'b0_0010_0000,
    ST_ADIV  = 9'b0_0100_0000,
    ST_LMUL  = 9'b0_1000_0000,
    ST_EMIT  = 9'b1_0000_0000
  } state_e;

  // configuration registers
  logic [SS_W-1:0]   sample_size_q;
  logic [PPB_W-1:0]  pix_per_blk_q;
  logic [FRAC_W-1:0] sample_frac_q;
  logic [FRAC_W-1:0] rel_limit_q;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BIN_W-1:0]  thr_q, thr_d;
  logic [BIN_W-1:0]  addr_q, addr_d;
  logic              last_q, last_d;
  logic [FRAC_W-1:0] k_q, k_d;
  logic [FRAC_W-1:0] rem_q, rem_d;
  logic [DIV_N_W-1:0] sum_q, sum_d;
  logic [BIN_W-1:0]  v_q, v_d;

  logic              out_vld_q, out_vld_d;
  logic              out_kind_q, out_kind_d;
  logic              out_lc_q, out_lc_d;
  logic [BIN_W-1:0]  out_lim_q, out_lim_d;

  hist_req_t         hreq;
  logic [CNT_W-1:0]  hist_wdata;
  logic [CNT_W-1:0]  hist_rdata;

  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quot;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic               out_free;
  logic               in_fire;
  logic [DIV_N_W-1:0] cnt_ext;
  logic [DIV_N_W-1:0] sampled;
  logic [FRAC_W-1:0]  k_raw;
  logic [MUL_A_W-1:0] bin_ext;
  logic [MUL_A_W-1:0] rem_ext;
  logic [MUL_A_W-1:0] take;
  logic [DIV_N_W-1:0] sum_nx;
  logic [DIV_D_W-1:0] ppb_safe;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // datapath terms used by the sequencer
  assign ppb_safe = (pix_per_blk_q == '0) ? DIV_D_W'(1) : pix_per_blk_q;
  assign cnt_ext  = DIV_N_W'(count_q);
  assign sampled  = (div_quot < cnt_ext) ? div_quot : cnt_ext;
  assign k_raw    = mul_p[2*FRAC_W-1:FRAC_W];
  assign bin_ext  = MUL_A_W'(hist_rdata);
  assign rem_ext  = MUL_A_W'(rem_q);
  assign take     = (bin_ext < rem_ext) ? bin_ext : rem_ext;
  assign sum_nx   = sum_q + mul_p[DIV_N_W-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    thr_d        = thr_q;
    addr_d       = addr_q;
    last_d       = last_q;
    k_d          = k_q;
    rem_d        = rem_q;
    sum_d        = sum_q;
    v_d          = v_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_kind_d   = out_kind_q;
    out_lc_d     = out_lc_q;
    out_lim_d    = out_lim_q;
    hreq         = '0;
    hist_wdata   = hist_rdata + CNT_W'(1);
    div_start    = 1'b0;
    div_dividend = DIV_N_W'(sample_size_q);
    div_divisor  = ppb_safe;
    mul_en       = 1'b0;
    mul_a        = sampled[MUL_A_W-1:0];
    mul_b        = sample_frac_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == OP_CLASSIFY) begin
            out_vld_d  = 1'b1;
            out_kind_d = KIND_CLASS;
            out_lc_d   = s_axis_tdata < thr_q;
            out_lim_d  = thr_q;
          end else if (count_q < CNT_W'(MAX_BLOCKS)) begin
            // read the bin now, write it back next cycle
            hreq.rd_en   = 1'b1;
            hreq.rd_addr = s_axis_tdata;
            addr_d       = s_axis_tdata;
            last_d       = s_axis_tlast;
            state_d      = ST_LOAD;
          end else if (s_axis_tlast) begin
            div_start = 1'b1;
            state_d   = ST_SDIV;
          end
        end
      end
      ST_LOAD: begin
        hreq.wr_en   = 1'b1;
        hreq.wr_addr = addr_q;
        count_d      = count_q + CNT_W'(1);
        if (last_q) begin
          div_start = 1'b1;
          state_d   = ST_SDIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SDIV: begin
        // blocks in budget, then scale by the sample fraction
        if (div_done) begin
          mul_en  = 1'b1;
          state_d = ST_KMUL;
        end
      end
      ST_KMUL: begin
        k_d          = (k_raw == '0) ? FRAC_W'(1) : k_raw;
        rem_d        = k_d;
        sum_d        = '0;
        v_d          = BIN_W'(NUM_BIN - 1);
        hreq.rd_en   = 1'b1;
        hreq.rd_addr = BIN_W'(NUM_BIN - 1);
        state_d      = ST_WTAKE;
      end
      ST_WTAKE: begin
        // take as many of this bin as are still wanted
        rem_d   = rem_q - take[FRAC_W-1:0];
        mul_en  = 1'b1;
        mul_a   = take;
        mul_b   = MUL_B_W'(v_q);
        state_d = ST_WACC;
      end
      ST_WACC: begin
        sum_d = sum_nx;
        if (rem_q == '0 || v_q == '0) begin
          div_start    = 1'b1;
          div_dividend = sum_nx;
          div_divisor  = DIV_D_W'(k_q);
          state_d      = ST_ADIV;
        end else begin
          v_d          = v_q - BIN_W'(1);
          hreq.rd_en   = 1'b1;
          hreq.rd_addr = v_q - BIN_W'(1);
          state_d      = ST_WTAKE;
        end
      end
      ST_ADIV: begin
        // average of the top values times the relative limit
        if (div_done) begin
          mul_en  = 1'b1;
          mul_a   = div_quot[MUL_A_W-1:0];
          mul_b   = rel_limit_q;
          state_d = ST_LMUL;
        end
      end
      ST_LMUL: begin
        thr_d    = mul_p[FRAC_W+BIN_W-1:FRAC_W];
        hreq.clr = 1'b1;
        count_d  = '0;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = KIND_LIMIT;
          out_lc_d   = 1'b0;
          out_lim_d  = thr_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      thr_q         <= '0;
      last_q        <= 1'b0;
      out_vld_q     <= 1'b0;
      sample_size_q <= SAMPLE_SIZE_RST;
      pix_per_blk_q <= PIX_PER_BLK_RST;
      sample_frac_q <= SAMPLE_FRAC_RST;
      rel_limit_q   <= REL_LIMIT_RST;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      thr_q     <= thr_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SAMPLE_SIZE: sample_size_q <= cfg_data_i[SS_W-1:0];
          CFG_PIX_PER_BLK: pix_per_blk_q <= cfg_data_i[PPB_W-1:0];
          CFG_SAMPLE_FRAC: sample_frac_q <= cfg_data_i[FRAC_W-1:0];
          CFG_REL_LIMIT:   rel_limit_q   <= cfg_data_i[FRAC_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    k_q        <= k_d;
    rem_q      <= rem_d;
    sum_q      <= sum_d;
    v_q        <= v_d;
    out_kind_q <= out_kind_d;
    out_lc_q   <= out_lc_d;
    out_lim_q  <= out_lim_d;
  end

  rlcm_hist #(
    .DATA_W (CNT_W)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hreq),
    .wr_data_i (hist_wdata),
    .rd_data_o (hist_rdata)
  );

  rlcm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  rlcm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_lim_q, out_lc_q};
  assign m_axis_tuser  = out_kind_q;

endmodule
